// ===== src/tle_pkg.sv =====
// shared types and constants for the terminal line editor
// no dependencies
package tle_pkg;

  localparam int LINE_SIZE_DEF = 16;
  localparam int QUEUE_DEPTH   = 4;

  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_ESC   = 8'h1B;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_LBRK  = 8'h5B;
  localparam logic [7:0] CH_UP    = 8'h41;
  localparam logic [7:0] CH_RIGHT = 8'h43;
  localparam logic [7:0] CH_LEFT  = 8'h44;
  localparam logic [7:0] CH_ERASE = 8'h4B;
  localparam logic [7:0] CH_DEL   = 8'h7F;
  localparam logic [7:0] UTF_MASK = 8'hC0;
  localparam logic [7:0] UTF_CONT = 8'h80;

  localparam logic [1:0] DEST_ECHO = 2'd0;
  localparam logic [1:0] DEST_LINE = 2'd1;
  localparam logic [1:0] DEST_END  = 2'd2;

  typedef enum logic [2:0] {
    CMD_INSERT,
    CMD_DELETE,
    CMD_NEWLINE,
    CMD_LEFT,
    CMD_RIGHT,
    CMD_UP
  } cmd_e;

  typedef struct packed {
    cmd_e       op;
    logic [7:0] data;
  } cmd_t;

endpackage

// ===== src/tle_front.sv =====
// front end: escape parser and byte classification into edit commands
// depends on tle_pkg
module tle_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          rx_valid_i,
  input  logic [7:0]    rx_byte_i,
  output logic          rx_stall_o,
  input  logic          full_i,
  output logic          push_o,
  output tle_pkg::cmd_t push_cmd_o
);
  import tle_pkg::*;

  localparam logic [1:0] ESC_NORMAL  = 2'd0;
  localparam logic [1:0] ESC_SEEN    = 2'd1;
  localparam logic [1:0] ESC_BRACKET = 2'd2;

  logic [1:0] esc_q, esc_d;
  logic       accept;
  logic       cmd_v;
  cmd_e       cmd_op;

  assign rx_stall_o = full_i;
  assign accept     = rx_valid_i && !full_i;

  always_comb begin
    esc_d  = ESC_NORMAL;
    cmd_v  = 1'b0;
    cmd_op = CMD_INSERT;
    case (esc_q)
      ESC_SEEN: begin
        esc_d = (rx_byte_i == CH_LBRK) ? ESC_BRACKET : ESC_NORMAL;
      end
      ESC_BRACKET: begin
        if (rx_byte_i == CH_UP) begin
          cmd_v = 1'b1; cmd_op = CMD_UP;
        end else if (rx_byte_i == CH_RIGHT) begin
          cmd_v = 1'b1; cmd_op = CMD_RIGHT;
        end else if (rx_byte_i == CH_LEFT) begin
          cmd_v = 1'b1; cmd_op = CMD_LEFT;
        end
      end
      default: begin
        if (rx_byte_i == CH_ESC) begin
          esc_d = ESC_SEEN;
        end else if (rx_byte_i == CH_LF) begin
          cmd_v = 1'b1; cmd_op = CMD_NEWLINE;
        end else if (rx_byte_i == CH_BS || rx_byte_i == CH_DEL) begin
          cmd_v = 1'b1; cmd_op = CMD_DELETE;
        end else if (rx_byte_i == CH_TAB || rx_byte_i >= CH_SPACE) begin
          cmd_v = 1'b1; cmd_op = CMD_INSERT;
        end
      end
    endcase
  end

  assign push_o          = accept && cmd_v;
  assign push_cmd_o.op   = cmd_op;
  assign push_cmd_o.data = rx_byte_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      esc_q <= ESC_NORMAL;
    end else if (accept) begin
      esc_q <= esc_d;
    end
  end

endmodule

// ===== src/tle_queue.sv =====
// short command queue between front and back
// depends on tle_pkg
module tle_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  tle_pkg::cmd_t push_cmd_i,
  output logic          full_o,
  output logic          valid_o,
  input  logic          pop_i,
  output tle_pkg::cmd_t pop_cmd_o
);
  import tle_pkg::*;

  localparam int PW = $clog2(QUEUE_DEPTH);

  cmd_t          mem_q [QUEUE_DEPTH];
  logic [PW:0]   wr_q, rd_q;

  assign valid_o   = (wr_q != rd_q);
  assign full_o    = (wr_q[PW-1:0] == rd_q[PW-1:0]) && (wr_q[PW] != rd_q[PW]);
  assign pop_cmd_o = mem_q[rd_q[PW-1:0]];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q[PW-1:0]] <= push_cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0;
      rd_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + (PW+1)'(1);
      if (pop_i)  rd_q <= rd_q + (PW+1)'(1);
    end
  end

endmodule

// ===== src/tle_back.sv =====
// back end: line store, cursor and echo sequencer with output register
// depends on tle_pkg
module tle_back #(
  parameter int LINE_SIZE = tle_pkg::LINE_SIZE_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cmd_valid_i,
  input  tle_pkg::cmd_t cmd_i,
  output logic          cmd_pop_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output logic [7:0]    out_byte_o,
  output logic [1:0]    destination_o,
  output logic [3:0]    line_length_o,
  output logic          run_last_o
);
  import tle_pkg::*;

  localparam int IW = $clog2(LINE_SIZE);
  localparam logic [IW-1:0] LAST_IDX = IW'(LINE_SIZE - 1);
  localparam logic [IW-1:0] ONE      = IW'(1);

  localparam logic [4:0] S_IDLE    = 5'd0;
  localparam logic [4:0] S_SHR     = 5'd1;
  localparam logic [4:0] S_INS     = 5'd2;
  localparam logic [4:0] S_E0      = 5'd3;
  localparam logic [4:0] S_E1      = 5'd4;
  localparam logic [4:0] S_E2      = 5'd5;
  localparam logic [4:0] S_RD_BY   = 5'd6;
  localparam logic [4:0] S_RD_BS   = 5'd7;
  localparam logic [4:0] S_SCAN    = 5'd8;
  localparam logic [4:0] S_DEL_ECH = 5'd9;
  localparam logic [4:0] S_SHL     = 5'd10;
  localparam logic [4:0] S_NL_CR   = 5'd11;
  localparam logic [4:0] S_NL_LF   = 5'd12;
  localparam logic [4:0] S_NL_BY   = 5'd13;
  localparam logic [4:0] S_NL_END  = 5'd14;
  localparam logic [4:0] S_UP_SCAN = 5'd15;
  localparam logic [4:0] S_UP_EMIT = 5'd16;

  logic [7:0]    store_q [LINE_SIZE];
  logic [4:0]    state_q, state_d;
  logic [IW-1:0] cur_q, cur_d, end_q, end_d, i_q, i_d, d_q, d_d, n_q, n_d, k_q, k_d;
  logic [1:0]    ph_q, ph_d;
  logic [7:0]    byte_q, byte_d, fin_q, fin_d;

  logic [IW-1:0] rd_addr, wr_addr;
  logic [7:0]    rd_data, wr_data;
  logic          wr_en;

  logic          em_v, em_last, can_emit, adv;
  logic [7:0]    em_byte;
  logic [1:0]    em_dest;
  logic [3:0]    em_len;

  logic          out_v_q;
  logic [7:0]    out_byte_q;
  logic [1:0]    out_dest_q;
  logic [3:0]    out_len_q;
  logic          out_last_q;

  assign can_emit = !out_v_q || !out_stall_i;
  assign rd_data  = store_q[rd_addr];

  always_comb begin
    case (state_q)
      S_SHR:   rd_addr = i_q - ONE;
      S_SCAN:  rd_addr = d_q;
      default: rd_addr = i_q;
    endcase
  end

  always_comb begin
    state_d = state_q;
    cur_d = cur_q; end_d = end_q; i_d = i_q; d_d = d_q; n_d = n_q; k_d = k_q;
    ph_d = ph_q; byte_d = byte_q; fin_d = fin_q;
    wr_en = 1'b0; wr_addr = i_q; wr_data = rd_data;
    em_v = 1'b0; em_byte = 8'h00; em_dest = DEST_ECHO; em_len = 4'd0; em_last = 1'b0;
    cmd_pop_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          case (cmd_i.op)
            CMD_INSERT: begin
              byte_d = cmd_i.data;
              if (end_q < LAST_IDX) begin
                i_d = end_q; state_d = S_SHR;
              end
            end
            CMD_DELETE: begin
              if (cur_q != '0) begin
                d_d = cur_q - ONE; state_d = S_SCAN;
              end
            end
            CMD_NEWLINE: begin
              wr_en = 1'b1; wr_addr = end_q; wr_data = 8'h00; state_d = S_NL_CR;
            end
            CMD_RIGHT: begin
              if (cur_q < end_q) begin
                cur_d = cur_q + ONE; fin_d = CH_RIGHT; state_d = S_E0;
              end
            end
            CMD_LEFT: begin
              if (cur_q != '0) begin
                cur_d = cur_q - ONE; fin_d = CH_LEFT; state_d = S_E0;
              end
            end
            CMD_UP: begin
              if (end_q == '0) begin
                i_d = '0; state_d = S_UP_SCAN;
              end
            end
            default: ;
          endcase
        end
      end
      S_SHR: begin
        if (i_q > cur_q) begin
          wr_en = 1'b1; wr_addr = i_q; wr_data = rd_data; i_d = i_q - ONE;
        end else begin
          state_d = S_INS;
        end
      end
      S_INS: begin
        em_v = 1'b1; em_byte = byte_q; em_last = (cur_q == end_q);
        if (can_emit) begin
          wr_en = 1'b1; wr_addr = cur_q; wr_data = byte_q;
          cur_d = cur_q + ONE; end_d = end_q + ONE;
          fin_d = CH_ERASE;
          state_d = (cur_q == end_q) ? S_IDLE : S_E0;
        end
      end
      S_E0: begin
        em_v = 1'b1; em_byte = CH_ESC;
        if (can_emit) state_d = S_E1;
      end
      S_E1: begin
        em_v = 1'b1; em_byte = CH_LBRK;
        if (can_emit) state_d = S_E2;
      end
      S_E2: begin
        em_v = 1'b1; em_byte = fin_q;
        em_last = (fin_q != CH_ERASE) || (cur_q == end_q);
        if (can_emit) begin
          i_d = cur_q;
          state_d = em_last ? S_IDLE : S_RD_BY;
        end
      end
      S_RD_BY: begin
        em_v = 1'b1; em_byte = rd_data;
        if (can_emit) begin
          if (i_q == end_q - ONE) begin
            i_d = cur_q; state_d = S_RD_BS;
          end else begin
            i_d = i_q + ONE;
          end
        end
      end
      S_RD_BS: begin
        em_v = 1'b1; em_byte = CH_BS; em_last = (i_q == end_q - ONE);
        if (can_emit) begin
          i_d = i_q + ONE;
          if (em_last) state_d = S_IDLE;
        end
      end
      S_SCAN: begin
        if (d_q != '0 && (rd_data & UTF_MASK) == UTF_CONT) begin
          d_d = d_q - ONE;
        end else begin
          n_d = cur_q - d_q; k_d = '0; ph_d = 2'd0; state_d = S_DEL_ECH;
        end
      end
      S_DEL_ECH: begin
        em_v = 1'b1; em_byte = (ph_q == 2'd1) ? CH_SPACE : CH_BS;
        if (can_emit) begin
          if (ph_q == 2'd2) begin
            ph_d = 2'd0;
            if (k_q == n_q - ONE) begin
              i_d = cur_q; state_d = S_SHL;
            end else begin
              k_d = k_q + ONE;
            end
          end else begin
            ph_d = ph_q + 2'd1;
          end
        end
      end
      S_SHL: begin
        if (i_q < end_q) begin
          wr_en = 1'b1; wr_addr = i_q - n_q; wr_data = rd_data; i_d = i_q + ONE;
        end else begin
          cur_d = d_q; end_d = end_q - n_q; fin_d = CH_ERASE; state_d = S_E0;
        end
      end
      S_NL_CR: begin
        em_v = 1'b1; em_byte = CH_CR;
        if (can_emit) state_d = S_NL_LF;
      end
      S_NL_LF: begin
        em_v = 1'b1; em_byte = CH_LF;
        if (can_emit) begin
          i_d = '0;
          state_d = (end_q == '0) ? S_NL_END : S_NL_BY;
        end
      end
      S_NL_BY: begin
        em_v = 1'b1; em_byte = rd_data; em_dest = DEST_LINE;
        if (can_emit) begin
          i_d = i_q + ONE;
          if (i_q == end_q - ONE) state_d = S_NL_END;
        end
      end
      S_NL_END: begin
        em_v = 1'b1; em_byte = 8'h00; em_dest = DEST_END; em_len = 4'(end_q);
        em_last = 1'b1;
        if (can_emit) begin
          cur_d = '0; end_d = '0; state_d = S_IDLE;
        end
      end
      S_UP_SCAN: begin
        if (i_q < LAST_IDX && rd_data != 8'h00) begin
          i_d = i_q + ONE;
        end else begin
          cur_d = i_q; end_d = i_q; i_d = '0;
          state_d = (i_q == '0) ? S_IDLE : S_UP_EMIT;
        end
      end
      S_UP_EMIT: begin
        em_v = 1'b1; em_byte = rd_data; em_last = (i_q == end_q - ONE);
        if (can_emit) begin
          i_d = i_q + ONE;
          if (em_last) state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign adv = em_v && can_emit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cur_q <= '0; end_q <= '0; i_q <= '0; d_q <= '0; n_q <= '0; k_q <= '0;
      ph_q <= '0; byte_q <= '0; fin_q <= '0;
      out_v_q <= 1'b0;
      for (int j = 0; j < LINE_SIZE; j++) store_q[j] <= 8'h00;
    end else begin
      state_q <= state_d;
      cur_q <= cur_d; end_q <= end_d; i_q <= i_d; d_q <= d_d; n_q <= n_d; k_q <= k_d;
      ph_q <= ph_d; byte_q <= byte_d; fin_q <= fin_d;
      if (wr_en) store_q[wr_addr] <= wr_data;
      if (adv) out_v_q <= 1'b1;
      else if (!out_stall_i) out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_byte_q <= em_byte;
      out_dest_q <= em_dest;
      out_len_q  <= em_len;
      out_last_q <= em_last;
    end
  end

  assign out_valid_o   = out_v_q;
  assign out_byte_o    = out_byte_q;
  assign destination_o = out_dest_q;
  assign line_length_o = out_len_q;
  assign run_last_o    = out_last_q;

endmodule

// ===== src/terminal_line_editor_unit.sv =====
// top level of the terminal line editor: front, command queue, back
// depends on tle_pkg, tle_front, tle_queue, tle_back
//
//  channel  direction  handshake              payload
//  rx       in         rx_valid_i/rx_stall_o  rx_byte_i
//  out      out        out_valid_o/out_stall_i out_byte_o destination_o
//                                              line_length_o run_last_o
//
// front decodes accepted bytes combinationally, queues edit commands
// the back runs one command at a time: store shifts or scanning plus
// one cycle per emitted byte while out is not stalled, at most
// 3*(LINE_SIZE-1)+3 bytes for the longest edit
// reset clears the store, cursor, end, escape parser and queue at once
// rx stalls only while the four-entry queue is full
// out stalls hold the back in its emitting states
module terminal_line_editor_unit #(
  parameter int LINE_SIZE = tle_pkg::LINE_SIZE_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       rx_valid_i,
  input  logic [7:0] rx_byte_i,
  output logic       rx_stall_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  output logic [1:0] destination_o,
  output logic [3:0] line_length_o,
  output logic       run_last_o
);
  import tle_pkg::*;

  // front to queue
  logic push, full;
  cmd_t push_cmd;
  // queue to back
  logic q_valid, pop;
  cmd_t pop_cmd;

  tle_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rx_valid_i (rx_valid_i),
    .rx_byte_i  (rx_byte_i),
    .rx_stall_o (rx_stall_o),
    .full_i     (full),
    .push_o     (push),
    .push_cmd_o (push_cmd)
  );

  tle_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .full_o     (full),
    .valid_o    (q_valid),
    .pop_i      (pop),
    .pop_cmd_o  (pop_cmd)
  );

  // back owns the line store and the output register
  tle_back #(.LINE_SIZE(LINE_SIZE)) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_valid_i   (q_valid),
    .cmd_i         (pop_cmd),
    .cmd_pop_o     (pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_byte_o    (out_byte_o),
    .destination_o (destination_o),
    .line_length_o (line_length_o),
    .run_last_o    (run_last_o)
  );

endmodule

// ===== src/tle_checker.sv =====
// port-level checks for the terminal line editor
// depends on tle_pkg and terminal_line_editor_unit
module tle_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [7:0] out_byte_o,
  input logic [1:0] destination_o,
  input logic [3:0] line_length_o,
  input logic       run_last_o
);
  import tle_pkg::*;

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_byte_o)
      && $stable(destination_o))
    else $error("stalled result changed");

  a_marker: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && destination_o == DEST_END |-> out_byte_o == 8'h00 && run_last_o)
    else $error("line end marker malformed");

  a_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && destination_o != DEST_END |-> line_length_o == 4'd0)
    else $error("length outside marker");

  a_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && destination_o == DEST_LINE |-> out_byte_o != 8'h00 && !run_last_o)
    else $error("bad completed line byte");

endmodule

bind terminal_line_editor_unit tle_checker u_tle_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .out_byte_o    (out_byte_o),
  .destination_o (destination_o),
  .line_length_o (line_length_o),
  .run_last_o    (run_last_o)
);
